// ===== hw/rtl/xmcs_pkg.sv =====
package xmcs_pkg;

    // Block geometry
    localparam int BLOCK_BYTES = 128;
    localparam int ADDR_W      = $clog2(BLOCK_BYTES);
    localparam int FRAME_HDR   = 3;
    localparam logic [7:0] BLOCK_LEN   = 8'(BLOCK_BYTES);
    localparam logic [7:0] FRAME_LAST  = 8'(FRAME_HDR + BLOCK_BYTES);

    // Link symbols
    localparam logic [7:0] SYM_SOH = 8'h01;
    localparam logic [7:0] SYM_EOT = 8'h04;
    localparam logic [7:0] SYM_ACK = 8'h06;
    localparam logic [7:0] SYM_NAK = 8'h15;
    localparam logic [7:0] SYM_CAN = 8'h18;
    localparam logic [7:0] SYM_PAD = 8'h1A;

    // Frame positions before the data bytes
    localparam logic [7:0] POS_SOH  = 8'd0;
    localparam logic [7:0] POS_BLK  = 8'd1;
    localparam logic [7:0] POS_NBLK = 8'd2;

    // Position inside the EOT phase
    localparam logic [7:0] EOT_PENDING = 8'd0;
    localparam logic [7:0] EOT_SENT    = 8'd1;

    localparam logic [7:0] RETRY_RESET = 8'd10;

    typedef enum logic [1:0] {
        MODE_DATA = 2'd0,
        MODE_RX   = 2'd1,
        MODE_SLOT = 2'd2,
        MODE_END  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        PH_LOAD       = 3'd0,
        PH_SEND       = 3'd1,
        PH_WAIT       = 3'd2,
        PH_EOT        = 3'd3,
        PH_DONE       = 3'd4,
        PH_FAIL_RETRY = 3'd5,
        PH_FAIL_IRREG = 3'd6,
        PH_FAIL_EOT   = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        ST_BUSY        = 3'd0,
        ST_READY       = 3'd1,
        ST_DONE        = 3'd2,
        ST_FAIL_RETRY  = 3'd3,
        ST_FAIL_IRREG  = 3'd4,
        ST_FAIL_EOT    = 3'd5
    } status_t;

    // Where the transmitted byte comes from
    typedef enum logic [1:0] {
        TXB_LIT = 2'd0,
        TXB_MEM = 2'd1,
        TXB_SUM = 2'd2
    } txb_src_t;

    // Result beat held in the output stage
    typedef struct packed {
        logic       tx_valid;
        txb_src_t   src;
        logic [7:0] lit;
        logic       sum_clr;
        logic       sum_add;
        status_t    status;
        logic [7:0] block_number;
        logic [7:0] retry_count;
    } beat_t;

endpackage

// ===== hw/rtl/xmcs_ram.sv =====
module xmcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/xmodem_checksum_sender.sv =====
// XMODEM sender with 128-byte blocks and an 8-bit byte-sum checksum. Each input
// beat carries a kind on s_tuser (0 payload byte, 1 byte received from the link,
// 2 transmit slot, 3 end of data) and a byte on s_tdata, and every input beat
// yields exactly one result beat holding tx_valid, tx_byte, status, the block
// number and the resend count after that event. Payload bytes fill a 128-entry
// block store; a frame is sent one byte per transmit slot (SOH, block number,
// its complement, 128 data bytes with 0x1A padding, checksum) once the
// receiver's first NAK has been seen. The block takes one beat per clock when the
// sink keeps up: the control state updates in the accept cycle and the store is
// read through its single registered read port, whose data lands directly in the
// output stage; the checksum accumulates as data beats leave. A new beat is
// accepted whenever the output stage is empty or being drained.
module xmodem_checksum_sender
    import xmcs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [0] tx_valid, [8:1] tx_byte, [11:9] status,
                                   // [19:12] block_number, [27:20] retry_count
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data   // [7:0] retry_limit
);

    phase_t     phase_reg, phase_next;
    logic [7:0] fill_reg, fill_next;
    logic [7:0] pos_reg, pos_next;
    logic [7:0] blk_reg, blk_next;
    logic [7:0] retry_reg, retry_next;
    logic       nak_seen_reg, nak_seen_next;
    logic       ended_reg, ended_next;
    logic [7:0] limit_reg;
    logic [7:0] sum_reg;
    logic       out_valid_reg;
    beat_t      out_reg, beat_next;

    logic              accept;
    logic              out_fire;
    mode_t             mode;
    logic              wr_en;
    logic [7:0]        data_pos;
    logic [7:0]        rd_data;
    logic [7:0]        tx_byte;

    assign accept   = s_tvalid && s_tready;
    assign out_fire = out_valid_reg && m_tready;
    assign s_tready = !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign mode     = mode_t'(s_tuser);
    assign data_pos = pos_reg - 8'(FRAME_HDR);

    xmcs_ram #(
        .WIDTH (8),
        .DEPTH (BLOCK_BYTES)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (fill_reg[ADDR_W-1:0]),
        .wr_data (s_tdata),
        .rd_en   (accept),
        .rd_addr (data_pos[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    function automatic status_t status_of(phase_t ph, logic ended);
        status_t st;
        st = ST_BUSY;
        unique case (ph)
            PH_DONE:       st = ST_DONE;
            PH_FAIL_RETRY: st = ST_FAIL_RETRY;
            PH_FAIL_IRREG: st = ST_FAIL_IRREG;
            PH_FAIL_EOT:   st = ST_FAIL_EOT;
            PH_LOAD:       st = ended ? ST_BUSY : ST_READY;
            default:       st = ST_BUSY;
        endcase
        return st;
    endfunction

    // Next state and result beat for the accepted input
    always_comb begin
        phase_next    = phase_reg;
        fill_next     = fill_reg;
        pos_next      = pos_reg;
        blk_next      = blk_reg;
        retry_next    = retry_reg;
        nak_seen_next = nak_seen_reg;
        ended_next    = ended_reg;
        wr_en         = 1'b0;

        beat_next          = '0;
        beat_next.src      = TXB_LIT;

        if (accept && phase_reg < PH_DONE) begin
            unique case (mode)
                MODE_DATA: begin
                    if (phase_reg == PH_LOAD && !ended_reg && fill_reg < BLOCK_LEN) begin
                        wr_en     = 1'b1;
                        fill_next = fill_reg + 8'd1;
                        if (fill_next >= BLOCK_LEN) begin
                            phase_next = PH_SEND;
                            pos_next   = POS_SOH;
                        end
                    end
                end
                MODE_END: begin
                    if (!ended_reg && phase_reg <= PH_WAIT) begin
                        ended_next = 1'b1;
                        if (phase_reg == PH_LOAD) begin
                            pos_next   = POS_SOH;
                            phase_next = (fill_reg != 8'd0) ? PH_SEND : PH_EOT;
                        end
                    end
                end
                MODE_RX: begin
                    if (!nak_seen_reg) begin
                        if (s_tdata == SYM_NAK) begin
                            nak_seen_next = 1'b1;
                        end
                    end else if (phase_reg == PH_WAIT) begin
                        if (s_tdata == SYM_ACK) begin
                            blk_next   = blk_reg + 8'd1;
                            retry_next = 8'd0;
                            fill_next  = 8'd0;
                            pos_next   = POS_SOH;
                            phase_next = ended_reg ? PH_EOT : PH_LOAD;
                        end else if (s_tdata == SYM_NAK) begin
                            if (retry_reg == limit_reg) begin
                                beat_next.tx_valid = 1'b1;
                                beat_next.lit      = SYM_CAN;
                                phase_next         = PH_FAIL_RETRY;
                            end else begin
                                retry_next = retry_reg + 8'd1;
                                pos_next   = POS_SOH;
                                phase_next = PH_SEND;
                            end
                        end else begin
                            beat_next.tx_valid = 1'b1;
                            beat_next.lit      = SYM_CAN;
                            phase_next         = PH_FAIL_IRREG;
                        end
                    end else if (phase_reg == PH_EOT && pos_reg == EOT_SENT) begin
                        if (s_tdata == SYM_ACK) begin
                            phase_next = PH_DONE;
                        end else begin
                            beat_next.tx_valid = 1'b1;
                            beat_next.lit      = SYM_CAN;
                            phase_next         = PH_FAIL_EOT;
                        end
                    end
                end
                MODE_SLOT: begin
                    if (nak_seen_reg && phase_reg == PH_SEND) begin
                        beat_next.tx_valid = 1'b1;
                        if (pos_reg == POS_SOH) begin
                            beat_next.lit     = SYM_SOH;
                            beat_next.sum_clr = 1'b1;
                        end else if (pos_reg == POS_BLK) begin
                            beat_next.lit = blk_reg;
                        end else if (pos_reg == POS_NBLK) begin
                            beat_next.lit = ~blk_reg;
                        end else if (pos_reg < FRAME_LAST) begin
                            beat_next.sum_add = 1'b1;
                            if (data_pos < fill_reg) begin
                                beat_next.src = TXB_MEM;
                            end else begin
                                beat_next.lit = SYM_PAD;
                            end
                        end else begin
                            beat_next.src = TXB_SUM;
                        end
                        if (pos_reg >= FRAME_LAST) begin
                            pos_next   = POS_SOH;
                            phase_next = PH_WAIT;
                        end else begin
                            pos_next = pos_reg + 8'd1;
                        end
                    end else if (nak_seen_reg && phase_reg == PH_EOT
                                 && pos_reg == EOT_PENDING) begin
                        beat_next.tx_valid = 1'b1;
                        beat_next.lit      = SYM_EOT;
                        pos_next           = EOT_SENT;
                    end
                end
                default: ;
            endcase
        end

        beat_next.status       = status_of(phase_next, ended_next);
        beat_next.block_number = blk_next;
        beat_next.retry_count  = retry_next;
    end

    // Advance control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_LOAD;
            fill_reg     <= 8'd0;
            pos_reg      <= 8'd0;
            blk_reg      <= 8'd1;
            retry_reg    <= 8'd0;
            nak_seen_reg <= 1'b0;
            ended_reg    <= 1'b0;
            limit_reg    <= RETRY_RESET;
        end else begin
            phase_reg    <= phase_next;
            fill_reg     <= fill_next;
            pos_reg      <= pos_next;
            blk_reg      <= blk_next;
            retry_reg    <= retry_next;
            nak_seen_reg <= nak_seen_next;
            ended_reg    <= ended_next;
            if (cfg_valid && cfg_ready) begin
                limit_reg <= cfg_data;
            end
        end
    end

    // Hold the result beat until the sink takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= beat_next;
        end
    end

    // Accumulate the checksum as data beats leave
    always_ff @(posedge aclk) begin
        if (out_fire) begin
            if (out_reg.sum_clr) begin
                sum_reg <= 8'd0;
            end else if (out_reg.sum_add) begin
                sum_reg <= sum_reg + tx_byte;
            end
        end
    end

    // Select the transmitted byte
    always_comb begin
        case (out_reg.src)
            TXB_MEM: tx_byte = rd_data;
            TXB_SUM: tx_byte = sum_reg;
            default: tx_byte = out_reg.lit;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg.retry_count, out_reg.block_number,
                       out_reg.status, tx_byte, out_reg.tx_valid};

endmodule
